// File: hdl/voxel_surface_visibility_macros.svh
// assertion macros for the voxel surface visibility block
`ifndef VOXEL_SURFACE_VISIBILITY_MACROS_SVH
`define VOXEL_SURFACE_VISIBILITY_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define VSV_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define VSV_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`else

`define VSV_ASSERT_NOW(lbl, ant, cons, msg)
`define VSV_ASSERT_NEXT(lbl, ant, cons, msg)

`endif

`endif

// File: hdl/vsv_pkg.sv
package vsv_pkg;

    localparam int DEF_SIZE_X = 16;
    localparam int DEF_SIZE_Y = 256;
    localparam int DEF_SIZE_Z = 16;

    localparam logic [1:0] OP_LOAD_VOX  = 2'd0;
    localparam logic [1:0] OP_LOAD_FACE = 2'd1;
    localparam logic [1:0] OP_QUERY     = 2'd2;

    localparam logic [1:0] SIDE_XN = 2'd0;
    localparam logic [1:0] SIDE_ZN = 2'd1;
    localparam logic [1:0] SIDE_XP = 2'd2;
    localparam logic [1:0] SIDE_ZP = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ZX,
        ST_BASE,
        ST_PZ,
        ST_PX,
        ST_FACE,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        STEP_C,
        STEP_XN,
        STEP_XP,
        STEP_YN,
        STEP_YP,
        STEP_ZN,
        STEP_ZP
    } step_t;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_CENTER,
        PEND_AIR
    } pend_t;

    typedef struct packed {
        logic vox_we;
        logic face_we;
        logic vox_re;
        logic face_re;
        logic wdata;
    } store_req_t;

endpackage

// File: hdl/vsv_store.sv
module vsv_store
    import vsv_pkg::*;
#(
    parameter int VOX_DEPTH  = DEF_SIZE_X * DEF_SIZE_Y * DEF_SIZE_Z,
    parameter int FACE_DEPTH = 4 * DEF_SIZE_X * DEF_SIZE_Y
)
(
    input  logic                          clk,
    input  store_req_t                    req,
    input  logic [$clog2(VOX_DEPTH)-1:0]  vox_addr,
    input  logic [$clog2(FACE_DEPTH)-1:0] face_addr,
    output logic                          rd_bit
);

    logic vox_mem  [VOX_DEPTH];
    logic face_mem [FACE_DEPTH];
    logic vox_q_reg;
    logic face_q_reg;
    logic face_sel_reg;

    always_ff @(posedge clk)
    begin
        if (req.vox_we)
        begin
            vox_mem[vox_addr] <= req.wdata;
        end
        if (req.vox_re)
        begin
            vox_q_reg <= vox_mem[vox_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.face_we)
        begin
            face_mem[face_addr] <= req.wdata;
        end
        if (req.face_re)
        begin
            face_q_reg <= face_mem[face_addr];
        end
        face_sel_reg <= req.face_re;
    end

    assign rd_bit = face_sel_reg ? face_q_reg : vox_q_reg;

endmodule

// File: hdl/voxel_surface_visibility.sv
// voxel surface visibility: face culling test over one chunk
//
// item channel (item_valid / item_stall) carries one word: op, x, y, z, side,
// face_pos, solid. op 0 loads a chunk voxel bit, op 1 loads a bit of the
// bordering face of a side neighbour, op 2 queries a voxel. result channel
// (result_valid / result_stall) carries visible and block_index, one word per
// in-range query; loads, out-of-range items and op 3 give no word.
// neighbor_present must be written (cfg_wr_en / cfg_wr_data) only while idle; the block does not check.
//
// one item at a time; item_stall is high while an item is worked on.
// query: four passes through the shared multiply-add unit for the addresses,
// then up to seven single-port bit reads (centre and six neighbours), then
// the result. voxel load: two address passes, then the write; face load: one
// address pass, then the write; an ignored word is dropped when it is taken.
// the result sits in an output register; a new item is taken while it waits,
// and a query that finishes while the receiver stalls holds until it drains.
// reset clears the sequencer, the output valid and neighbor_present; the
// bit stores are not cleared and must be loaded before they are queried.
module voxel_surface_visibility
    import vsv_pkg::*;
#(
    parameter int SIZE_X = DEF_SIZE_X,
    parameter int SIZE_Y = DEF_SIZE_Y,
    parameter int SIZE_Z = DEF_SIZE_Z
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  op,
    input  logic [3:0]  x,
    input  logic [7:0]  y,
    input  logic [3:0]  z,
    input  logic [1:0]  side,
    input  logic [3:0]  face_pos,
    input  logic        solid,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        visible,
    output logic [15:0] block_index,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data
);

`include "voxel_surface_visibility_macros.svh"

    localparam int FACE_LEN   = (SIZE_X > SIZE_Z) ? SIZE_X : SIZE_Z;
    localparam int VOX_DEPTH  = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int FACE_SPAN  = FACE_LEN * SIZE_Y;
    localparam int FACE_DEPTH = 4 * FACE_SPAN;
    localparam int VOX_AW     = $clog2(VOX_DEPTH);
    localparam int FACE_AW    = $clog2(FACE_DEPTH);
    localparam int ACC_W      = (VOX_AW > FACE_AW) ? VOX_AW : FACE_AW;

    localparam logic [ACC_W-1:0] MUL_SX  = ACC_W'(SIZE_X);
    localparam logic [ACC_W-1:0] MUL_SY  = ACC_W'(SIZE_Y);
    localparam logic [ACC_W-1:0] OFF_X   = ACC_W'(SIZE_Y);
    localparam logic [ACC_W-1:0] OFF_Y   = ACC_W'(1);
    localparam logic [ACC_W-1:0] OFF_Z   = ACC_W'(SIZE_X * SIZE_Y);
    localparam logic [ACC_W-1:0] SPAN_ZN = ACC_W'(FACE_SPAN);
    localparam logic [ACC_W-1:0] SPAN_XP = ACC_W'(2 * FACE_SPAN);
    localparam logic [ACC_W-1:0] SPAN_ZP = ACC_W'(3 * FACE_SPAN);

    state_t     state_reg, state_next;
    step_t      step_reg, step_next;
    pend_t      pend_reg, pend_next;
    logic       result_valid_reg, result_valid_next;
    logic [3:0] present_reg, present_next;

    logic [1:0] op_reg;
    logic [3:0] x_reg;
    logic [7:0] y_reg;
    logic [3:0] z_reg;
    logic [1:0] side_reg;
    logic [3:0] pos_reg;
    logic       solid_reg;

    logic [ACC_W-1:0] zx_reg;
    logic [ACC_W-1:0] base_reg;
    logic [ACC_W-1:0] pz_reg;
    logic [ACC_W-1:0] px_reg;
    logic             center_reg;
    logic             open_reg;
    logic             visible_reg;
    logic [15:0]      index_reg;

    logic             accept;
    logic             vox_ok;
    logic             face_ok;
    logic             out_free;
    logic             x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
    logic [ACC_W-1:0] mul_a, mul_b, mul_c, mac_sum;
    logic [ACC_W-1:0] mem_addr;
    logic             const_open;
    store_req_t       req;
    logic             rd_bit;

    assign accept   = item_valid && !item_stall;
    assign out_free = !result_valid_reg || !result_stall;
    assign vox_ok   = (32'(x) < 32'(SIZE_X)) && (32'(y) < 32'(SIZE_Y))
                      && (32'(z) < 32'(SIZE_Z));
    assign face_ok  = (32'(face_pos) < (side[0] ? 32'(SIZE_X) : 32'(SIZE_Z)))
                      && (32'(y) < 32'(SIZE_Y));

    assign x_lo = (x_reg == 4'd0);
    assign x_hi = (32'(x_reg) == 32'(SIZE_X - 1));
    assign y_lo = (y_reg == 8'd0);
    assign y_hi = (32'(y_reg) == 32'(SIZE_Y - 1));
    assign z_lo = (z_reg == 4'd0);
    assign z_hi = (32'(z_reg) == 32'(SIZE_Z - 1));

    // shared multiply-add unit
    assign mac_sum = mul_a * mul_b + mul_c;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_LOAD_VOX:  state_next = vox_ok ? ST_ZX : ST_IDLE;
                        OP_LOAD_FACE: state_next = face_ok ? ST_FACE : ST_IDLE;
                        OP_QUERY:     state_next = vox_ok ? ST_ZX : ST_IDLE;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ZX:    state_next = ST_BASE;
            ST_BASE:  state_next = (op_reg == OP_QUERY) ? ST_PZ : ST_WRITE;
            ST_PZ:    state_next = ST_PX;
            ST_PX:    state_next = ST_READ;
            ST_FACE:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            ST_READ:  state_next = (step_reg == STEP_ZP) ? ST_DRAIN : ST_READ;
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE:  state_next = out_free ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        item_stall = (state_reg != ST_IDLE);
        mul_a      = ACC_W'(y_reg);
        mul_b      = MUL_SY;
        mul_c      = ACC_W'(y_reg);
        mem_addr   = base_reg;
        const_open = 1'b0;
        pend_next  = PEND_NONE;
        step_next  = step_reg;
        req        = '{vox_we: 1'b0, face_we: 1'b0, vox_re: 1'b0, face_re: 1'b0,
                       wdata: solid_reg};
        result_valid_next = result_valid_reg && result_stall;
        case (state_reg)
            ST_ZX:
            begin
                mul_a = ACC_W'(z_reg);
                mul_b = MUL_SX;
                mul_c = ACC_W'(x_reg);
            end
            ST_BASE:
            begin
                mul_a = zx_reg;
            end
            ST_PZ:
            begin
                mul_a = ACC_W'(z_reg);
            end
            ST_PX:
            begin
                mul_a     = ACC_W'(x_reg);
                step_next = STEP_C;
            end
            ST_FACE:
            begin
                mul_a = ACC_W'(pos_reg);
            end
            ST_WRITE:
            begin
                if (op_reg == OP_LOAD_FACE)
                begin
                    req.face_we = 1'b1;
                    case (side_reg)
                        SIDE_XN: mem_addr = pz_reg;
                        SIDE_ZN: mem_addr = pz_reg + SPAN_ZN;
                        SIDE_XP: mem_addr = pz_reg + SPAN_XP;
                        default: mem_addr = pz_reg + SPAN_ZP;
                    endcase
                end
                else
                begin
                    req.vox_we = 1'b1;
                end
            end
            ST_READ:
            begin
                step_next = step_t'(step_reg + 3'd1);
                pend_next = PEND_AIR;
                case (step_reg)
                    STEP_C:
                    begin
                        req.vox_re = 1'b1;
                        pend_next  = PEND_CENTER;
                    end
                    STEP_XN:
                    begin
                        if (!x_lo)
                        begin
                            req.vox_re = 1'b1;
                            mem_addr   = base_reg - OFF_X;
                        end
                        else if (present_reg[SIDE_XN])
                        begin
                            req.face_re = 1'b1;
                            mem_addr    = pz_reg;
                        end
                        else
                        begin
                            const_open = 1'b1;
                            pend_next  = PEND_NONE;
                        end
                    end
                    STEP_XP:
                    begin
                        if (!x_hi)
                        begin
                            req.vox_re = 1'b1;
                            mem_addr   = base_reg + OFF_X;
                        end
                        else if (present_reg[SIDE_XP])
                        begin
                            req.face_re = 1'b1;
                            mem_addr    = pz_reg + SPAN_XP;
                        end
                        else
                        begin
                            const_open = 1'b1;
                            pend_next  = PEND_NONE;
                        end
                    end
                    STEP_YN:
                    begin
                        if (!y_lo)
                        begin
                            req.vox_re = 1'b1;
                            mem_addr   = base_reg - OFF_Y;
                        end
                        else
                        begin
                            const_open = 1'b1;
                            pend_next  = PEND_NONE;
                        end
                    end
                    STEP_YP:
                    begin
                        if (!y_hi)
                        begin
                            req.vox_re = 1'b1;
                            mem_addr   = base_reg + OFF_Y;
                        end
                        else
                        begin
                            const_open = 1'b1;
                            pend_next  = PEND_NONE;
                        end
                    end
                    STEP_ZN:
                    begin
                        if (!z_lo)
                        begin
                            req.vox_re = 1'b1;
                            mem_addr   = base_reg - OFF_Z;
                        end
                        else if (present_reg[SIDE_ZN])
                        begin
                            req.face_re = 1'b1;
                            mem_addr    = px_reg + SPAN_ZN;
                        end
                        else
                        begin
                            const_open = 1'b1;
                            pend_next  = PEND_NONE;
                        end
                    end
                    STEP_ZP:
                    begin
                        if (!z_hi)
                        begin
                            req.vox_re = 1'b1;
                            mem_addr   = base_reg + OFF_Z;
                        end
                        else if (present_reg[SIDE_ZP])
                        begin
                            req.face_re = 1'b1;
                            mem_addr    = px_reg + SPAN_ZP;
                        end
                        else
                        begin
                            const_open = 1'b1;
                            pend_next  = PEND_NONE;
                        end
                    end
                    default:
                    begin
                        pend_next = PEND_NONE;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                end
            end
            default:
            begin
                mul_a = ACC_W'(y_reg);
            end
        endcase
    end

    assign present_next = cfg_wr_en ? cfg_wr_data : present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= STEP_C;
            pend_reg         <= PEND_NONE;
            result_valid_reg <= 1'b0;
            present_reg      <= 4'd0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
            present_reg      <= present_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            x_reg     <= x;
            y_reg     <= y;
            z_reg     <= z;
            side_reg  <= side;
            pos_reg   <= face_pos;
            solid_reg <= solid;
            open_reg  <= 1'b0;
        end
        else if (const_open || (pend_reg == PEND_AIR && !rd_bit))
        begin
            open_reg <= 1'b1;
        end
        case (state_reg)
            ST_ZX:   zx_reg   <= mac_sum;
            ST_BASE: base_reg <= mac_sum;
            ST_PZ:   pz_reg   <= mac_sum;
            ST_FACE: pz_reg   <= mac_sum;
            ST_PX:   px_reg   <= mac_sum;
            default: zx_reg   <= zx_reg;
        endcase
        if (pend_reg == PEND_CENTER)
        begin
            center_reg <= rd_bit;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            visible_reg <= center_reg && open_reg;
            index_reg   <= 16'(base_reg);
        end
    end

    vsv_store #(
        .VOX_DEPTH  (VOX_DEPTH),
        .FACE_DEPTH (FACE_DEPTH)
    ) u_store (
        .clk       (clk),
        .req       (req),
        .vox_addr  (mem_addr[VOX_AW-1:0]),
        .face_addr (mem_addr[FACE_AW-1:0]),
        .rd_bit    (rd_bit)
    );

    assign result_valid = result_valid_reg;
    assign visible      = visible_reg;
    assign block_index  = index_reg;

    `VSV_ASSERT_NOW(a_result_from_done, $rose(result_valid_reg), $past(state_reg == ST_DONE), "result raised outside done")
    `VSV_ASSERT_NOW(a_center_after_first_read, pend_reg == PEND_CENTER, $past(state_reg == ST_READ && step_reg == STEP_C), "centre bit pending out of order")
    `VSV_ASSERT_NEXT(a_write_one_cycle, state_reg == ST_WRITE, state_reg == ST_IDLE, "write did not return to idle")
    `VSV_ASSERT_NOW(a_single_read, req.vox_re || req.face_re, state_reg == ST_READ && !(req.vox_re && req.face_re), "store read outside read phase")

endmodule
